// ===== rtl/core/atkd_pkg.sv =====
`default_nettype none

package atkd_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned BANKS         = 3;
	localparam int unsigned LANES         = 4;
	localparam int unsigned EDGE_PAD      = 4;
	localparam int unsigned THRESHOLD     = 128;
	localparam int unsigned WHITE_LEVEL   = 255;
	localparam int unsigned SHIFT_AMOUNT  = 3;

	localparam logic [10:0] LINE_WIDTH_RST = 11'd1024;

	// role of a physical bank relative to the current-row pointer
	localparam logic [1:0] ROLE_CUR   = 2'd0;
	localparam logic [1:0] ROLE_NEXT  = 2'd1;
	localparam logic [1:0] ROLE_AFTER = 2'd2;

	// one stored error: generation tag plus signed 8-bit value
	typedef struct packed {
		logic       tag;
		logic [7:0] val;
	} atkd_entry_t;

	// offset k in 1..4 such that column + k falls in the given lane
	function automatic logic [2:0] lane_offset(input logic [1:0] col_lsb, input logic [1:0] lane);
		logic [1:0] d;
		d = lane - col_lsb - 2'd1;
		return {1'b0, d} + 3'd1;
	endfunction

	function automatic logic [1:0] role_of(input logic [1:0] bank, input logic [1:0] cur);
		logic [2:0] d;
		d = {1'b0, bank} + 3'd3 - {1'b0, cur};
		if (d >= 3'd3)
			d = d - 3'd3;
		return d[1:0];
	endfunction

	function automatic logic [7:0] sat8(input logic signed [9:0] v);
		if (v > 10'sd127)
			return 8'h7f;
		else if (v < -10'sd128)
			return 8'h80;
		else
			return v[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atkd_lane.sv =====
`default_nettype none

// One lane of one error bank: a 1W/2R memory of tagged entries, one-deep write
// forwarding, and a sweep engine that rebases tags after a row clear (or zeroes
// the lane after reset).
module atkd_lane #(
	parameter int unsigned LANE_DEPTH = 257,
	parameter int unsigned LANE       = 0,
	parameter int unsigned AW         = $clog2(LANE_DEPTH),
	parameter int unsigned SW         = AW + 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_val,
	input  wire logic          gen,
	input  wire logic [SW-1:0] span,
	input  wire logic          sweep_start,
	output logic      [7:0]    rd_val,
	output logic               busy
);
	import atkd_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(LANE_DEPTH - 1);
	localparam logic [1:0]    LANE_ID   = 2'(LANE);

	atkd_entry_t mem [LANE_DEPTH];

	atkd_entry_t   rd_a_q, rd_b_q, lw_data_q, raw_a, raw_b, mem_wd;
	logic [AW-1:0] rd_addr_q, lw_addr_q, ptr_q, ptr_d, mem_wa;
	logic          lw_valid_q, init_q, busy_q, sw_rd_q, busy_d, mem_we, sw_adv;
	logic [7:0]    eff_b;

	// an entry with a stale tag inside the clear span reads as zero
	function automatic logic [7:0] resolve(input atkd_entry_t e, input logic [AW-1:0] a,
			input logic g, input logic [SW-1:0] s);
		logic [SW-1:0] idx;
		idx = SW'({a, LANE_ID});
		if (e.tag == g || idx >= s)
			return e.val;
		else
			return 8'd0;
	endfunction

	assign raw_a  = (lw_valid_q && lw_addr_q == rd_addr_q) ? lw_data_q : rd_a_q;
	assign raw_b  = (lw_valid_q && lw_addr_q == ptr_q) ? lw_data_q : rd_b_q;
	assign rd_val = resolve(raw_a, rd_addr_q, gen, span);
	assign eff_b  = resolve(raw_b, ptr_q, gen, span);
	assign busy   = busy_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = '{tag: gen, val: eff_b};
		sw_adv = 1'b0;
		if (wr_en) begin
			// pixel write owns the port; it also settles the sweep entry if it hits it
			mem_we = 1'b1;
			mem_wa = wr_addr;
			mem_wd = '{tag: gen, val: wr_val};
			sw_adv = busy_q && !init_q && (wr_addr == ptr_q);
		end else if (busy_q && (init_q || sw_rd_q)) begin
			mem_we = 1'b1;
			mem_wd = '{tag: gen, val: (init_q ? 8'd0 : eff_b)};
			sw_adv = 1'b1;
		end
	end

	always_comb begin
		if (sweep_start)
			ptr_d = '0;
		else if (sw_adv && ptr_q == LAST_ADDR)
			ptr_d = '0;
		else if (sw_adv)
			ptr_d = ptr_q + AW'(1);
		else
			ptr_d = ptr_q;
		busy_d = sweep_start || (busy_q && !(sw_adv && ptr_q == LAST_ADDR));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b1;
			busy_q     <= 1'b1;
			sw_rd_q    <= 1'b0;
			ptr_q      <= '0;
			lw_valid_q <= 1'b0;
		end else begin
			init_q     <= init_q && busy_d;
			busy_q     <= busy_d;
			sw_rd_q    <= busy_d;
			ptr_q      <= ptr_d;
			lw_valid_q <= mem_we;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
		lw_addr_q <= mem_wa;
		lw_data_q <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_a_q <= mem[rd_addr];
		rd_b_q <= mem[ptr_d];
	end

endmodule

`default_nettype wire

// ===== rtl/core/atkd_pix.sv =====
`default_nettype none

// Pixel stage: add the stored error, clamp, threshold, and build the six
// saturating error updates for the lanes of the three banks.
module atkd_pix #(
	parameter int unsigned ROW_DEPTH = 1028,
	parameter int unsigned AW        = 9
) (
	input  wire logic                                        valid,
	input  wire logic [7:0]                                  gray,
	input  wire logic [9:0]                                  column,
	input  wire logic [1:0]                                  cur,
	input  wire logic [atkd_pkg::BANKS-1:0][atkd_pkg::LANES-1:0][7:0] rd_val,
	output logic                                             pixel_bit,
	output logic [atkd_pkg::BANKS-1:0][atkd_pkg::LANES-1:0]  wr_en,
	output logic [atkd_pkg::LANES-1:0][AW-1:0]               wr_addr,
	output logic [atkd_pkg::BANKS-1:0][atkd_pkg::LANES-1:0][7:0] wr_val
);
	import atkd_pkg::*;

	logic [2:0]        k   [LANES];
	logic [10:0]       idx [LANES];
	logic              inr [LANES];
	logic [1:0]        l2;
	logic [7:0]        cur_val;
	logic signed [9:0] sum;
	logic [7:0]        sum8;
	logic signed [8:0] diff, err;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			k[l]       = lane_offset(column[1:0], 2'(l));
			idx[l]     = {1'b0, column} + 11'(k[l]);
			inr[l]     = 32'(idx[l]) < ROW_DEPTH;
			wr_addr[l] = AW'(idx[l][10:2]);
		end
	end

	always_comb begin
		l2      = column[1:0] + 2'd2;
		cur_val = inr[l2] ? rd_val[cur][l2] : 8'd0;
		sum     = $signed({2'b00, gray}) + $signed({{2{cur_val[7]}}, cur_val});
		if (sum < 10'sd0)
			sum8 = 8'd0;
		else if (sum > 10'sd255)
			sum8 = 8'hff;
		else
			sum8 = sum[7:0];
		pixel_bit = sum8 >= 8'(THRESHOLD);
		diff      = pixel_bit ? $signed({1'b0, sum8}) - $signed(9'(WHITE_LEVEL))
		                      : $signed({1'b0, sum8});
		err       = diff >>> SHIFT_AMOUNT;
	end

	always_comb begin : upd
		logic [1:0] role;
		logic       hit;
		for (int p = 0; p < BANKS; p++) begin
			role = role_of(2'(p), cur);
			for (int l = 0; l < LANES; l++) begin
				// current row takes +1,+2 ahead; next row -1..+1; after-next row 0
				unique case (role)
					ROLE_CUR:   hit = (k[l] == 3'd3) || (k[l] == 3'd4);
					ROLE_NEXT:  hit = (k[l] != 3'd4);
					ROLE_AFTER: hit = (k[l] == 3'd2);
					default:    hit = 1'b0;
				endcase
				wr_en[p][l]  = valid && inr[l] && hit;
				wr_val[p][l] = sat8($signed({{2{rd_val[p][l][7]}}, rd_val[p][l]})
				                    + $signed({err[8], err}));
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/atkinson_dither_1bit.sv =====
`default_nettype none

// 1-bit Atkinson error-diffusion ditherer.
// Input channel (in_valid/in_ready) carries one gray pixel with its column and
// a row_end flag; output channel (out_valid/out_ready) returns one pixel_bit
// per input beat, in order. cfg_wr_en/cfg_wr_data write line_width, which only
// sets how many error entries are cleared at each row end; write it while idle.
// An accepted beat is registered into the pixel stage; its result then enters
// the output buffer. Throughput: one beat per cycle unless held off by a stall.
// Errors live in three banks of four interleaved lane memories (1W/2R each),
// so the read of the pixel's own error and the read-modify-write of its six
// neighbors close in one stage with one-deep forwarding from the previous write.
// A row end clears the old current row by a tag flip and starts a background
// sweep of that bank (MAX_WIDTH/4+1 lane entries, one per free write slot);
// a further row_end beat is held off until that sweep ends, other beats flow.
// Reset: a zeroing pass over all MAX_WIDTH/4+1 lane entries runs first, in_ready
// stays low meanwhile; line_width returns to 1024.
// A stalled receiver backs up into a two-beat output buffer, then in_ready
// drops; nothing is lost.
module atkinson_dither_1bit #(
	parameter int unsigned MAX_WIDTH = atkd_pkg::MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  gray_level,
	input  wire logic [9:0]  column,
	input  wire logic        row_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             pixel_bit,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data
);
	import atkd_pkg::*;

	localparam int unsigned ROW_DEPTH  = MAX_WIDTH + EDGE_PAD;
	localparam int unsigned LANE_DEPTH = (ROW_DEPTH + LANES - 1) / LANES;
	localparam int unsigned AW         = $clog2(LANE_DEPTH);
	localparam int unsigned SW         = AW + 3;

	logic                              valid_s1, row_end_s1;
	logic [7:0]                        gray_s1;
	logic [9:0]                        column_s1;
	logic [10:0]                       line_width_q;
	logic [1:0]                        cur_q;
	logic [BANKS-1:0]                  gen_q;
	logic [BANKS-1:0][SW-1:0]          span_q;
	logic [SW-1:0]                     span_new;
	logic [31:0]                       lw_cap;
	logic [BANKS-1:0]                  sweep_start;
	logic [BANKS*LANES-1:0]            lane_busy;
	logic                              sweep_busy;
	logic                              zeroed_q;
	logic [LANES-1:0][10:0]            rd_idx;
	logic [LANES-1:0][AW-1:0]          rd_addr;
	logic [BANKS-1:0][LANES-1:0][7:0]  rd_val;
	logic [BANKS-1:0][LANES-1:0]       wr_en;
	logic [LANES-1:0][AW-1:0]          wr_addr;
	logic [BANKS-1:0][LANES-1:0][7:0]  wr_val;
	logic                              bit_s1;
	logic [1:0]                        fifo_q;
	logic [1:0]                        cnt_q;
	logic                              push, pop, accept, rotate;
	logic [2:0]                        occ;

	assign sweep_busy = |lane_busy;
	assign accept     = in_valid && in_ready;
	assign rotate     = valid_s1 && row_end_s1;
	assign push       = valid_s1;
	assign pop        = out_valid && out_ready;
	assign out_valid  = (cnt_q != 2'd0);
	assign pixel_bit  = fifo_q[0];
	assign occ        = 3'(cnt_q) + 3'(valid_s1) - 3'(pop);

	// hold input during the zeroing pass after reset and while the output buffer is
	// full, and hold a row_end beat until the previous clear sweep is done
	assign in_ready = (zeroed_q || !sweep_busy) && (occ <= 3'd1)
	                  && !(row_end && (sweep_busy || rotate));

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rd_idx[l]  = {1'b0, column} + 11'(lane_offset(column[1:0], 2'(l)));
			rd_addr[l] = AW'(rd_idx[l][10:2]);
		end
		for (int p = 0; p < BANKS; p++)
			sweep_start[p] = rotate && (cur_q == 2'(p));
		lw_cap   = (32'(line_width_q) > MAX_WIDTH) ? MAX_WIDTH : 32'(line_width_q);
		span_new = SW'(lw_cap + EDGE_PAD);
	end

	for (genvar p = 0; p < BANKS; p++) begin : g_bank
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			atkd_lane #(
				.LANE_DEPTH (LANE_DEPTH),
				.LANE       (l),
				.AW         (AW),
				.SW         (SW)
			) u_lane (
				.clk         (clk),
				.arst_n      (arst_n),
				.rd_addr     (rd_addr[l]),
				.wr_en       (wr_en[p][l]),
				.wr_addr     (wr_addr[l]),
				.wr_val      (wr_val[p][l]),
				.gen         (gen_q[p]),
				.span        (span_q[p]),
				.sweep_start (sweep_start[p]),
				.rd_val      (rd_val[p][l]),
				.busy        (lane_busy[p*LANES+l])
			);
		end
	end

	atkd_pix #(
		.ROW_DEPTH (ROW_DEPTH),
		.AW        (AW)
	) u_pix (
		.valid     (valid_s1),
		.gray      (gray_s1),
		.column    (column_s1),
		.cur       (cur_q),
		.rd_val    (rd_val),
		.pixel_bit (bit_s1),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_val    (wr_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			line_width_q <= LINE_WIDTH_RST;
			cur_q        <= 2'd0;
			gen_q        <= '0;
			span_q       <= '0;
			cnt_q        <= 2'd0;
			zeroed_q     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (!sweep_busy)
				zeroed_q <= 1'b1;
			if (cfg_wr_en)
				line_width_q <= cfg_wr_data;
			if (rotate) begin
				// old current row becomes the after-next row: flip its tag, set span
				gen_q[cur_q]  <= !gen_q[cur_q];
				span_q[cur_q] <= span_new;
				cur_q         <= (cur_q == 2'(BANKS - 1)) ? 2'd0 : cur_q + 2'd1;
			end
			cnt_q <= 2'(3'(cnt_q) + 3'(push) - 3'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1    <= gray_level;
			column_s1  <= column;
			row_end_s1 <= row_end;
		end
		if (push && pop) begin
			if (cnt_q == 2'd2) begin
				fifo_q[0] <= fifo_q[1];
				fifo_q[1] <= bit_s1;
			end else begin
				fifo_q[0] <= bit_s1;
			end
		end else if (push) begin
			fifo_q[cnt_q[0]] <= bit_s1;
		end else if (pop) begin
			fifo_q[0] <= fifo_q[1];
		end
	end

	a_row_end_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && row_end) |-> !sweep_busy)
		else $error("row_end beat accepted during a clear sweep");

	a_rotate_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		rotate |=> sweep_busy)
		else $error("row rotation did not start a clear sweep");

	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cnt_q != 2'd2 || pop))
		else $error("output buffer overflow");

	a_rotate_moves: assert property (@(posedge clk) disable iff (!arst_n)
		rotate |=> (cur_q != $past(cur_q)))
		else $error("current row pointer did not advance");

endmodule

`default_nettype wire
